// ----- design/nsf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared constants and types for the sentence framer.
// ----------------------------------------------------------------------------
package nsf_pkg;

  localparam int BUF_BYTES = 64;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int TICK_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TO = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_TO = CFG_IDX_W'(1);

  localparam logic [TICK_W-1:0] IDLE_TO_RST = TICK_W'(1000);
  localparam logic [TICK_W-1:0] CHAR_TO_RST = TICK_W'(100);

  // Item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_BODY  = 2'd1,
    PH_LF    = 2'd2,
    PH_CS    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EM_IDLE = 2'd0,
    EM_READ = 2'd1,
    EM_LOAD = 2'd2,
    EM_TERM = 2'd3
  } em_state_t;

  // Framer -> emitter request
  typedef struct packed {
    logic              valid;
    logic              timeout;
    logic [ADDR_W-1:0] count;
  } emit_req_t;

endpackage

// ----- design/nsf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nsf_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/nsf_framer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_framer
// Sentence state machine: checksum, fill pointer, timeouts, buffer writes.
// ----------------------------------------------------------------------------
module nsf_framer (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   acc,
  input  logic                                   kind,
  input  logic [7:0]                             rx_byte,
  input  logic                                   cfg_wr_en,
  input  logic [nsf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [nsf_pkg::CFG_W-1:0]              cfg_data,
  output logic                                   wr_en,
  output logic [nsf_pkg::ADDR_W-1:0]             wr_addr,
  output logic [7:0]                             wr_data,
  output nsf_pkg::emit_req_t                     req
);
  import nsf_pkg::*;

  localparam logic [ADDR_W-1:0] FILL_MAX = ADDR_W'(BUF_BYTES - 1);

  phase_t              phase_r, phase_nxt;
  logic [7:0]          xor_r, xor_nxt;
  logic [ADDR_W-1:0]   fill_r, fill_nxt;
  logic                hexidx_r, hexidx_nxt;
  logic [7:0]          first_r, first_nxt;
  logic [TICK_W-1:0]   ticks_r, ticks_nxt;
  logic [TICK_W-1:0]   idle_to_r, char_to_r;

  logic [TICK_W-1:0]   limit;
  logic [TICK_W-1:0]   ticks_inc;
  logic                to_hit;
  logic [7:0]          cs_hi;
  logic [7:0]          cs_rx;
  logic                is_tick, is_byte;

  function automatic logic [7:0] hex_value(input logic [7:0] c);
    if (c > CH_NINE) begin
      return c - HEX_ALPHA_OFS;
    end
    return c - CH_ZERO;
  endfunction

  assign is_tick = acc && (kind == KIND_TICK);
  assign is_byte = acc && (kind == KIND_BYTE);

  // A zero limit fires on the first tick anyway since ticks_inc is never 0.
  assign limit     = (phase_r == PH_START) ? idle_to_r : char_to_r;
  assign ticks_inc = (ticks_r != '1) ? ticks_r + TICK_W'(1) : ticks_r;
  assign to_hit    = ticks_inc >= limit;
  assign cs_hi     = hex_value(first_r);
  assign cs_rx     = {cs_hi[3:0], 4'h0} + hex_value(rx_byte);

  // Next state
  always_comb begin
    phase_nxt  = phase_r;
    xor_nxt    = xor_r;
    fill_nxt   = fill_r;
    hexidx_nxt = hexidx_r;
    first_nxt  = first_r;
    ticks_nxt  = ticks_r;
    if (is_tick) begin
      if (to_hit) begin
        phase_nxt  = PH_START;
        hexidx_nxt = 1'b0;
        ticks_nxt  = '0;
      end else begin
        ticks_nxt = ticks_inc;
      end
    end else if (is_byte) begin
      ticks_nxt = '0;
      case (phase_r)
        PH_START: begin
          if (rx_byte == CH_DOLLAR) begin
            xor_nxt   = '0;
            fill_nxt  = '0;
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (rx_byte == CH_CR) begin
            phase_nxt = PH_LF;
          end else if (rx_byte == CH_STAR) begin
            hexidx_nxt = 1'b0;
            phase_nxt  = PH_CS;
          end else if (fill_r == FILL_MAX) begin
            phase_nxt  = PH_START;   // overlong frame dropped
            hexidx_nxt = 1'b0;
          end else begin
            xor_nxt  = xor_r ^ rx_byte;
            fill_nxt = fill_r + ADDR_W'(1);
          end
        end
        PH_LF: begin
          phase_nxt  = PH_START;
          hexidx_nxt = 1'b0;
        end
        PH_CS: begin
          if (!hexidx_r) begin
            first_nxt  = rx_byte;
            hexidx_nxt = 1'b1;
          end else begin
            hexidx_nxt = 1'b0;
            phase_nxt  = (cs_rx == xor_r) ? PH_BODY : PH_START;
          end
        end
        default: begin
          phase_nxt = PH_START;
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = fill_r;
    wr_data     = (rx_byte inside {CH_CR, CH_STAR, CH_COMMA}) ? 8'h00 : rx_byte;
    req.valid   = 1'b0;
    req.timeout = 1'b0;
    req.count   = fill_r;
    if (is_tick && to_hit) begin
      req.valid   = 1'b1;
      req.timeout = 1'b1;
    end else if (is_byte) begin
      case (phase_r)
        PH_BODY: begin
          wr_en = (rx_byte inside {CH_CR, CH_STAR}) || (fill_r != FILL_MAX);
        end
        PH_LF: begin
          req.valid = (rx_byte == CH_LF);
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      xor_r     <= '0;
      fill_r    <= '0;
      hexidx_r  <= 1'b0;
      first_r   <= '0;
      ticks_r   <= '0;
      idle_to_r <= IDLE_TO_RST;
      char_to_r <= CHAR_TO_RST;
    end else begin
      phase_r  <= phase_nxt;
      xor_r    <= xor_nxt;
      fill_r   <= fill_nxt;
      hexidx_r <= hexidx_nxt;
      first_r  <= first_nxt;
      ticks_r  <= ticks_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_IDLE_TO: idle_to_r <= cfg_data;
          REG_CHAR_TO: char_to_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  a_wr_only_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (phase_r == PH_BODY))
    else $error("buffer write outside sentence body");

  a_tick_clears_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
    is_byte |=> (ticks_r == '0))
    else $error("tick count not cleared by byte");

endmodule

// ----- design/nsf_emitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_emitter
// Streams the stored sentence out of the buffer, or sends a timeout event.
// ----------------------------------------------------------------------------
module nsf_emitter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nsf_pkg::emit_req_t          req,
  output logic                        busy,
  output logic                        rd_en,
  output logic [nsf_pkg::ADDR_W-1:0]  rd_addr,
  input  logic [7:0]                  rd_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_event_res,
  output logic [7:0]                  out_frame_char,
  output logic                        out_last
);
  import nsf_pkg::*;

  em_state_t          state_r, state_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0]  cnt_r, cnt_nxt;
  logic               to_r, to_nxt;

  logic               out_valid_r;
  logic               ev_r, last_r;
  logic [7:0]         ch_r;

  logic               slot_free;
  logic               load;
  logic               ld_ev, ld_last;
  logic [7:0]         ld_ch;

  assign slot_free = !out_valid_r || !out_stall;
  assign busy      = (state_r != EM_IDLE);
  assign rd_addr   = idx_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    to_nxt    = to_r;
    case (state_r)
      EM_IDLE: begin
        if (req.valid) begin
          cnt_nxt   = req.count;
          idx_nxt   = '0;
          to_nxt    = req.timeout;
          state_nxt = req.timeout ? EM_TERM : EM_READ;
        end
      end
      EM_READ: begin
        state_nxt = (idx_r == cnt_r) ? EM_TERM : EM_LOAD;
      end
      EM_LOAD: begin
        if (slot_free) begin
          idx_nxt   = idx_r + ADDR_W'(1);
          state_nxt = EM_READ;
        end
      end
      EM_TERM: begin
        if (slot_free) begin
          state_nxt = EM_IDLE;
        end
      end
      default: begin
        state_nxt = EM_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    rd_en   = 1'b0;
    load    = 1'b0;
    ld_ev   = 1'b0;
    ld_ch   = rd_data;
    ld_last = 1'b0;
    case (state_r)
      EM_READ: begin
        rd_en = (idx_r != cnt_r);
      end
      EM_LOAD: begin
        load = slot_free;
      end
      EM_TERM: begin
        load    = slot_free;
        ld_ev   = to_r;
        ld_ch   = 8'h00;
        ld_last = 1'b1;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EM_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      to_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      to_r    <= to_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_r   <= ld_ev;
      ch_r   <= ld_ch;
      last_r <= ld_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = ev_r;
  assign out_frame_char = ch_r;
  assign out_last       = last_r;

  a_req_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> (state_r == EM_IDLE))
    else $error("emit request while emitter busy");

  a_idx_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != EM_IDLE) |-> (idx_r <= cnt_r))
    else $error("read index past sentence length");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("loaded item not presented");

  a_term_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == EM_TERM && slot_free) |=> (state_r == EM_IDLE && out_last))
    else $error("terminator not flagged last");

endmodule

// ----- design/nmea_sentence_framer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_framer_core
// NMEA 0183 style sentence framer with XOR checksum check and rx timeouts.
// ----------------------------------------------------------------------------
// Each input item is either a received byte or one timer tick. A byte or a
// tick updates the framer state when it is taken; the sentence body goes
// into a 64 x 8 buffer RAM (commas and the '*'/CR positions stored as
// zero). A CR LF pair after a valid sentence streams the stored body plus a
// zero terminator flagged last: a sentence of N body bytes gives N + 1 output
// items (each body byte is read from the RAM and then loaded into the output
// register), and the input is stalled for that whole burst. A timeout emits
// one item with event_res = 1 and last = 1 and stalls the input until that
// item is loaded. Output stalls stretch either case. The output register
// lets the last item of a burst wait while the next input items are taken;
// a new burst then holds at its first load until that item leaves.
// Configuration: index 0 = idle timeout, index 1 = inter
// character timeout, both in ticks; a value of zero behaves as one. The
// buffer needs no clear after reset: only bytes written in the current
// sentence are ever read back.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // input items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [7:0]                     in_rx_byte,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_event_res,
  output logic [7:0]                     out_frame_char,
  output logic                           out_last,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [nsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nsf_pkg::CFG_W-1:0]      cfg_data
);
  import nsf_pkg::*;

  logic               acc;
  logic               em_busy;
  emit_req_t          req;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [7:0]         wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [7:0]         rd_data;

  // Input held off only while a burst or timeout event is being sent.
  assign in_stall = em_busy;
  assign acc      = in_valid && !in_stall;

  nsf_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .kind      (in_kind),
    .rx_byte   (in_rx_byte),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .req       (req)
  );

  // Sentence buffer: writes happen only while framing, reads only while
  // streaming, so the two ports never touch the same entry in one cycle.
  nsf_ram #(
    .DEPTH (BUF_BYTES),
    .WIDTH (8)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  nsf_emitter u_emitter (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (req),
    .busy           (em_busy),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_res  (out_event_res),
    .out_frame_char (out_frame_char),
    .out_last       (out_last)
  );

endmodule
